// ----- sv/atpam_pkg.sv -----
// ----------------------------------------------------------------------------
// atpam_pkg: shared types and constants of the three-point mapper
// Holds the calibration record, the divider request and response records,
// the register indexes of the configuration port and the datapath widths.
// ----------------------------------------------------------------------------
package atpam_pkg;

  // Raw sample and calibration widths.
  localparam int unsigned SMP_W  = 10;
  localparam int unsigned Q88_W  = 16;
  // Magnitude of (sample span) * (output span) needs 26 bits.
  localparam int unsigned MAG_W  = 26;
  // Divisor magnitude: an analog span.
  localparam int unsigned DVS_W  = 10;
  // Signed width of the product and of the mapped result before saturation.
  localparam int unsigned PROD_W = 28;
  // Signed width of an analog difference and of a digital span.
  localparam int unsigned ADIF_W = 11;
  localparam int unsigned DSPN_W = 17;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_AMIN,
    REG_ACEN,
    REG_AMAX,
    REG_DMIN,
    REG_DCEN,
    REG_DMAX
  } reg_idx_t;

  typedef struct packed {
    logic        [SMP_W-1:0] amin;
    logic        [SMP_W-1:0] acen;
    logic        [SMP_W-1:0] amax;
    logic signed [Q88_W-1:0] dmin;
    logic signed [Q88_W-1:0] dcen;
    logic signed [Q88_W-1:0] dmax;
  } cal_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [MAG_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- sv/averaged_three_point_adc_mapper_unit.sv -----
// ----------------------------------------------------------------------------
// averaged_three_point_adc_mapper_unit: moving average with three-point
// piecewise linear calibration of a 10-bit potentiometer reading
// Each input beat passes an average step, which forms the window average by
// reciprocal multiply; then the sample and the average are mapped in turn,
// each by a multiply step, a pass through the shared divider (start, 26
// quotient bits, done) and a finish step. A segment of zero width skips its
// divider pass. in_tready is high only while the sequencer is idle, so a new
// item is taken only once the last result has been handed off, and a waiting
// result holds the sequencer only at the hand-off of the next result.
// Reset (synchronous, rst_n low) empties the window, zeroes the running sum,
// loads the default calibration and drops any pending result.
// ----------------------------------------------------------------------------
module averaged_three_point_adc_mapper_unit #(
  parameter int unsigned AVG_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input beats. in_tdata: [9:0] sample, [15:10] zero.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // Result beats. out_tdata: [9:0] last_sample, [19:10] window_average,
  // [35:20] mapped_sample, [51:36] mapped_average, [55:52] zero.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,
  // Calibration registers.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned SMP_W  = atpam_pkg::SMP_W;
  localparam int unsigned Q88_W  = atpam_pkg::Q88_W;
  localparam int unsigned PROD_W = atpam_pkg::PROD_W;
  localparam int unsigned ADIF_W = atpam_pkg::ADIF_W;
  localparam int unsigned DSPN_W = atpam_pkg::DSPN_W;
  localparam int unsigned MAG_W  = atpam_pkg::MAG_W;
  localparam int unsigned DVS_W  = atpam_pkg::DVS_W;
  localparam int unsigned SUM_W  = 16;

  // Reciprocal of the window depth. With a 22-bit shift the rounded-up
  // reciprocal gives the exact truncated quotient of any 16-bit sum for depths
  // up to 64.
  localparam int unsigned RCP_SH = 22;
  localparam int unsigned RCP_W  = RCP_SH + 1;
  localparam int unsigned APRD_W = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_M =
    RCP_W'(((64'd1 << RCP_SH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(32768);

  // Sequencer: average step, then for the sample and then the average
  // one multiply step, one divider pass and one finish step; then hand-off.
  typedef enum logic [2:0] {
    S_IDLE,
    S_AVG,
    S_MUL,
    S_DIV,
    S_FIN,
    S_OUT
  } state_t;

  state_t state_r;
  logic   pass_r;      // low while mapping the sample, high for the average
  logic   go_r;        // one-cycle start pulse to the divider
  logic   out_tvalid_r;

  atpam_pkg::cal_t     cal;
  atpam_pkg::div_req_t div_req;
  atpam_pkg::div_rsp_t div_rsp;

  // The window is a shift line: of the stored taps, only the oldest is read outside the shift.
  logic [SMP_W-1:0] win_r [AVG_DEPTH];
  logic [SUM_W-1:0] sum_r;

  logic [SMP_W-1:0] samp_r;
  logic [SMP_W-1:0] avg_r;
  logic [Q88_W-1:0] map_samp_r;
  logic [Q88_W-1:0] map_avg_r;
  logic [55:0]      out_data_r;

  // Per-pass mapping registers.
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ADIF_W-1:0] den_r;
  logic signed [Q88_W-1:0]  base_r;
  logic                     lower_r;
  logic                     zero_r;

  logic                     in_acc;
  logic [SMP_W-1:0]         in_sample;
  logic [APRD_W-1:0]        avg_prod;
  logic [SMP_W-1:0]         v;
  logic                     lower_c;
  logic signed [ADIF_W-1:0] den_c;
  logic signed [ADIF_W-1:0] dif_c;
  logic signed [DSPN_W-1:0] span_c;
  logic signed [PROD_W-1:0] prod_c;
  logic [PROD_W-1:0]        prod_mag;
  logic [ADIF_W-1:0]        den_mag;
  logic signed [PROD_W-1:0] q_s;
  logic signed [PROD_W-1:0] r_raw;
  logic signed [PROD_W-1:0] r_clmp;
  logic [Q88_W-1:0]         map_res;
  logic                     out_free;

  atpam_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cal         (cal)
  );

  atpam_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_sample = in_tdata[SMP_W-1:0];
  assign out_free  = !out_tvalid_r || out_tready;

  // Window and running sum. The sum wraps at 16 bits, which never happens
  // for depths up to 64.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(AVG_DEPTH); i++) begin
        win_r[i] <= '0;
      end
      sum_r <= '0;
    end else if (in_acc) begin
      for (int i = 0; i + 1 < int'(AVG_DEPTH); i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[AVG_DEPTH-1] <= in_sample;
      sum_r <= sum_r - SUM_W'(win_r[0]) + SUM_W'(in_sample);
    end
  end

  // Window average: the sum times the reciprocal, shifted back down.
  assign avg_prod = APRD_W'(sum_r) * APRD_W'(RCP_M);

  // Segment selection and the product of the two spans for the value being
  // mapped in this pass.
  always_comb begin
    v       = pass_r ? avg_r : samp_r;
    lower_c = (v <= cal.acen);
    if (lower_c) begin
      den_c  = $signed({1'b0, cal.acen}) - $signed({1'b0, cal.amin});
      dif_c  = $signed({1'b0, v}) - $signed({1'b0, cal.amin});
      span_c = DSPN_W'(cal.dcen) - DSPN_W'(cal.dmin);
    end else begin
      den_c  = $signed({1'b0, cal.amax}) - $signed({1'b0, cal.acen});
      dif_c  = $signed({1'b0, v}) - $signed({1'b0, cal.acen});
      span_c = DSPN_W'(cal.dmax) - DSPN_W'(cal.dcen);
    end
    prod_c = PROD_W'(dif_c) * PROD_W'(span_c);
  end

  // The divider works on magnitudes; the quotient sign is restored after,
  // which gives truncation toward zero.
  always_comb begin
    prod_mag = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
    den_mag  = den_r[ADIF_W-1] ? ADIF_W'(-den_r) : ADIF_W'(den_r);
    div_req.start    = go_r;
    div_req.dividend = prod_mag[MAG_W-1:0];
    div_req.divisor  = den_mag[DVS_W-1:0];
  end

  // Finish step: offset, or the centre output for a zero-width segment,
  // one-sided clamp of the segment, then saturation to the signed 16-bit range.
  always_comb begin
    q_s = PROD_W'(div_rsp.quotient);
    if (prod_r[PROD_W-1] ^ den_r[ADIF_W-1]) begin
      q_s = -q_s;
    end
    if (zero_r) begin
      r_raw = PROD_W'(cal.dcen);
    end else begin
      r_raw = PROD_W'(base_r) + q_s;
    end
    r_clmp = r_raw;
    if (lower_r) begin
      if (r_raw < PROD_W'(cal.dmin)) begin
        r_clmp = PROD_W'(cal.dmin);
      end
    end else begin
      if (r_raw > PROD_W'(cal.dmax)) begin
        r_clmp = PROD_W'(cal.dmax);
      end
    end
    if (r_clmp > SAT_HI) begin
      map_res = Q88_W'(SAT_HI);
    end else if (r_clmp < SAT_LO) begin
      map_res = Q88_W'(SAT_LO);
    end else begin
      map_res = r_clmp[Q88_W-1:0];
    end
  end

  // Sequencer with its registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pass_r       <= 1'b0;
      go_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // A divider pass starts from the multiply step unless the segment has
      // zero width.
      go_r <= (state_r == S_MUL) && (den_c != '0);
      // In the hand-off state the new result replaces one leaving this edge.
      if (out_tvalid_r && out_tready && state_r != S_OUT) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            pass_r  <= 1'b0;
            state_r <= S_AVG;
          end
        end
        S_AVG: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (den_c == '0) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (pass_r) begin
            state_r <= S_OUT;
          end else begin
            pass_r  <= 1'b1;
            state_r <= S_MUL;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      samp_r <= in_sample;
    end
    if (state_r == S_AVG) begin
      avg_r <= avg_prod[RCP_SH +: SMP_W];
    end
    if (state_r == S_MUL) begin
      prod_r  <= prod_c;
      den_r   <= den_c;
      lower_r <= lower_c;
      zero_r  <= (den_c == '0);
      base_r  <= lower_c ? cal.dmin : cal.dcen;
    end
    if (state_r == S_FIN) begin
      if (pass_r) begin
        map_avg_r <= map_res;
      end else begin
        map_samp_r <= map_res;
      end
    end
    if (state_r == S_OUT && out_free) begin
      out_data_r <= {4'd0, map_avg_r, map_samp_r, avg_r, samp_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // The divider is never left running while the block takes a new item.
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while sequencer idle");

  // A divider result only arrives in the state that waits for it.
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider result arrived unexpectedly");

  // Every accepted beat starts the average step in the next cycle.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_AVG))
    else $error("accepted beat did not start the average step");

  // The lower segment never maps below the calibrated output minimum.
  a_lower_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && lower_r) |-> ($signed(map_res) >= cal.dmin))
    else $error("lower segment result below output minimum");

endmodule

// ----- sv/atpam_div.sv -----
// ----------------------------------------------------------------------------
// atpam_div: shared iterative unsigned divider
// Restoring division, one quotient bit per cycle, MAG_W quotient bits per request.
// ----------------------------------------------------------------------------
module atpam_div (
  input  logic               clk,
  input  logic               rst_n,
  input  atpam_pkg::div_req_t req,
  output atpam_pkg::div_rsp_t rsp
);

  localparam int unsigned CNT_W = $clog2(atpam_pkg::MAG_W);

  logic                         busy_r;
  logic                         done_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [atpam_pkg::DVS_W-1:0]  rem_r;
  logic [atpam_pkg::DVS_W-1:0]  dvs_r;
  logic [atpam_pkg::MAG_W-1:0]  quo_r;

  logic [atpam_pkg::DVS_W:0]    trial;
  logic [atpam_pkg::DVS_W:0]    diff;
  logic                         ge;
  logic [atpam_pkg::DVS_W-1:0]  rem_nxt;
  logic [atpam_pkg::MAG_W-1:0]  quo_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[atpam_pkg::MAG_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[atpam_pkg::DVS_W-1:0] : trial[atpam_pkg::DVS_W-1:0];
    quo_nxt = {quo_r[atpam_pkg::MAG_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(atpam_pkg::MAG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      rem_r <= '0;
      dvs_r <= req.divisor;
      quo_r <= req.dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ----- sv/atpam_cfg.sv -----
// ----------------------------------------------------------------------------
// atpam_cfg: calibration register file behind the APB-style port
// Six registers at byte addresses 4*i; writes to other indexes are dropped.
// ----------------------------------------------------------------------------
module atpam_cfg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [4:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output atpam_pkg::cal_t  cal
);

  atpam_pkg::cal_t cal_r;
  logic            wr_en;
  logic [2:0]      idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r.amin <= 10'd0;
      cal_r.acen <= 10'd512;
      cal_r.amax <= 10'd1023;
      cal_r.dmin <= -16'sd256;
      cal_r.dcen <= 16'sd0;
      cal_r.dmax <= 16'sd256;
    end else if (wr_en) begin
      case (idx)
        atpam_pkg::REG_AMIN: cal_r.amin <= cfg_pwdata[9:0];
        atpam_pkg::REG_ACEN: cal_r.acen <= cfg_pwdata[9:0];
        atpam_pkg::REG_AMAX: cal_r.amax <= cfg_pwdata[9:0];
        atpam_pkg::REG_DMIN: cal_r.dmin <= cfg_pwdata[15:0];
        atpam_pkg::REG_DCEN: cal_r.dcen <= cfg_pwdata[15:0];
        atpam_pkg::REG_DMAX: cal_r.dmax <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      atpam_pkg::REG_AMIN: cfg_prdata = {22'd0, cal_r.amin};
      atpam_pkg::REG_ACEN: cfg_prdata = {22'd0, cal_r.acen};
      atpam_pkg::REG_AMAX: cfg_prdata = {22'd0, cal_r.amax};
      atpam_pkg::REG_DMIN: cfg_prdata = {16'd0, cal_r.dmin};
      atpam_pkg::REG_DCEN: cfg_prdata = {16'd0, cal_r.dcen};
      atpam_pkg::REG_DMAX: cfg_prdata = {16'd0, cal_r.dmax};
      default:             cfg_prdata = 32'd0;
    endcase
  end

  assign cal = cal_r;

endmodule

// ----- test/averaged_three_point_adc_mapper_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// averaged_three_point_adc_mapper_unit_test: self-checking bench of the mapper
// Streams 10-bit samples into the block under many calibration settings and
// checks every result beat against a local model of the window average and the
// three-point mapping. The sender works in bursts with random gaps, the
// receiver stalls on its own changing pattern, and calibration is rewritten
// and read back between phases while the block is idle.
// ----------------------------------------------------------------------------
module averaged_three_point_adc_mapper_unit_test;

  localparam int WINDOW_DEPTH  = 8;
  // Cycles without any accepted beat before the run is declared hung. The
  // slowest correct stretch is the long receiver hold plus one item latency.
  localparam int HANG_LIMIT    = 4000;
  localparam int LONG_HOLD     = 800;
  localparam int RANDOM_ITEMS  = 1850;
  localparam int DRAIN_CYCLES  = 200;
  localparam int MAX_PRINTED   = 40;

  // One expected result beat.
  typedef struct {
    logic [9:0]  last_sample;
    logic [9:0]  window_average;
    logic [15:0] mapped_sample;
    logic [15:0] mapped_average;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  averaged_three_point_adc_mapper_unit #(.AVG_DEPTH(WINDOW_DEPTH)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  // Model state: the sample window, its running sum and the calibration as
  // the block should hold it. Calibration only changes while the block is idle.
  logic [9:0]  window_taps [WINDOW_DEPTH];
  logic [15:0] window_total;
  logic [15:0] cal_reg [6];

  logic [9:0]  sample_q [$];          // samples still to be offered
  reading_t    pending_readings [$];  // results owed by the block

  logic in_taken = 1'b0;              // an input beat happened at the last edge
  int   burst_left = 1;
  int   gap_left = 0;
  int   rx_mode = 0;
  int   rx_cycle = 0;
  int   hold_left = 0;
  int   hold_requests = 0;
  int   holds_served = 0;
  int   idle_cycles = 0;
  int   mismatches = 0;
  int   samples_taken = 0;
  int   results_seen = 0;
  int   settings_applied = 0;

  // Piecewise linear map through the three calibrated points, exact integer
  // arithmetic with truncation toward zero, then the segment clamp and the
  // final saturation to the signed 16-bit range.
  function automatic logic [15:0] map_to_q88(input logic [9:0] v);
    longint x, amin, acen, amax, dmin, dcen, dmax, den, r;
    x    = v;
    amin = cal_reg[atpam_pkg::REG_AMIN][9:0];
    acen = cal_reg[atpam_pkg::REG_ACEN][9:0];
    amax = cal_reg[atpam_pkg::REG_AMAX][9:0];
    dmin = $signed(cal_reg[atpam_pkg::REG_DMIN]);
    dcen = $signed(cal_reg[atpam_pkg::REG_DCEN]);
    dmax = $signed(cal_reg[atpam_pkg::REG_DMAX]);
    if (x <= acen) begin
      den = acen - amin;
      if (den == 0) r = dcen;
      else r = dmin + ((x - amin) * (dcen - dmin)) / den;
      if (r < dmin) r = dmin;
    end else begin
      den = amax - acen;
      if (den == 0) r = dcen;
      else r = dcen + ((x - acen) * (dmax - dcen)) / den;
      if (r > dmax) r = dmax;
    end
    if (r < -32768) r = -32768;
    if (r > 32767) r = 32767;
    return r[15:0];
  endfunction

  // Shifts one sample into the window and returns the result it should cause.
  function automatic reading_t advance_window(input logic [9:0] s);
    reading_t res;
    logic [9:0] avg;
    window_total = window_total - window_taps[0] + s;
    for (int i = 0; i + 1 < WINDOW_DEPTH; i++) window_taps[i] = window_taps[i + 1];
    window_taps[WINDOW_DEPTH - 1] = s;
    avg = 10'(window_total / WINDOW_DEPTH);
    res.last_sample    = s;
    res.window_average = avg;
    res.mapped_sample  = map_to_q88(s);
    res.mapped_average = map_to_q88(avg);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("mismatch: %s got %h want %h (result %0d)", what, got, want, results_seen);
  endtask

  // Input driver. Items leave the queue in bursts; after each burst a random
  // gap follows, sometimes none, so offers land on every phase of the block's
  // work. The valid is computed once per edge and assigned once.
  always @(negedge clk) begin
    logic offer_now;
    offer_now = in_tvalid && !in_taken;
    if (rst_n && !offer_now) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (sample_q.size() > 0) begin
        in_tdata <= {6'b0, sample_q.pop_front()};
        offer_now = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 130);
        end
      end
    end
    in_tvalid <= offer_now;
  end

  // Result receiver. It switches between always ready, coin flips, a fixed
  // one-in-four pattern and sparse random readiness, one chance in eight. A
  // long hold, asked for by the stimulus, keeps it off so the block backs up.
  always @(negedge clk) begin
    if (rx_cycle == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_cycle = $urandom_range(64, 400);
    end else begin
      rx_cycle--;
    end
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= (rx_cycle % 4 == 0);
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Monitor: checks result beats against the oldest expectation first, then
  // books the expectation of an input beat taken at the same edge. It also
  // runs the hang watchdog.
  always @(posedge clk) begin
    reading_t want;
    logic in_beat, out_beat;
    in_beat  = rst_n && in_tvalid && in_tready;
    out_beat = rst_n && out_tvalid && out_tready;
    in_taken <= in_beat;
    if (out_beat) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("result beat with nothing outstanding", out_tdata[15:0], 16'h0);
      end else begin
        want = pending_readings.pop_front();
        if (out_tdata[9:0] !== want.last_sample)
          report_mismatch("last_sample", out_tdata[9:0], want.last_sample);
        if (out_tdata[19:10] !== want.window_average)
          report_mismatch("window_average", out_tdata[19:10], want.window_average);
        if (out_tdata[35:20] !== want.mapped_sample)
          report_mismatch("mapped_sample", out_tdata[35:20], want.mapped_sample);
        if (out_tdata[51:36] !== want.mapped_average)
          report_mismatch("mapped_average", out_tdata[51:36], want.mapped_average);
      end
      results_seen++;
    end
    if (in_beat) begin
      pending_readings.push_back(advance_window(in_tdata[9:0]));
      samples_taken++;
    end
    if (in_beat || out_beat || cfg_psel) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results owed", idle_cycles,
               pending_readings.size());
      $display("tb: failure");
      $finish;
    end
  end

  // One configuration transfer: setup cycle, then access until pready.
  task automatic cfg_xfer(input bit wr, input atpam_pkg::reg_idx_t idx,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = wr;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = wr ? wdata : 32'h0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // Reads every register back and compares the bits it is wide.
  task automatic verify_cal();
    logic [31:0] rd, mask;
    for (int i = 0; i < 6; i++) begin
      cfg_xfer(1'b0, atpam_pkg::reg_idx_t'(i), 32'h0, rd);
      mask = (i < 3) ? 32'h3FF : 32'hFFFF;
      if ((rd & mask) !== ({16'h0, cal_reg[i]} & mask))
        report_mismatch("register read back", rd[15:0], cal_reg[i]);
    end
  endtask

  task automatic apply_cal(input logic [9:0] amin, acen, amax,
                           input logic [15:0] dmin, dcen, dmax);
    logic [15:0] vals [6];
    logic [31:0] rd;
    vals[0] = amin;
    vals[1] = acen;
    vals[2] = amax;
    vals[3] = dmin;
    vals[4] = dcen;
    vals[5] = dmax;
    for (int i = 0; i < 6; i++) begin
      cfg_xfer(1'b1, atpam_pkg::reg_idx_t'(i), {16'h0, vals[i]}, rd);
      cal_reg[i] = vals[i];
    end
    verify_cal();
    settings_applied++;
  endtask

  task automatic offer(input int s);
    sample_q.push_back(s[9:0]);
  endtask

  // Waits until every queued sample has gone in and every result came out.
  task automatic drain();
    do @(posedge clk);
    while (sample_q.size() != 0 || in_tvalid || pending_readings.size() != 0);
  endtask

  // Picks a calibration: mostly ordered stops, some full-scale extremes,
  // some zero-width segments, the rest anything at all.
  task automatic random_cal();
    int amin, acen, amax, dmin, dcen, dmax;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        amin = $urandom_range(0, 400);
        acen = $urandom_range(amin, 700);
        amax = $urandom_range(acen, 1023);
        dmin = -int'($urandom_range(0, 32768));
        dmax = $urandom_range(0, 32767);
        dcen = dmin + int'($urandom_range(0, dmax - dmin));
        if ($urandom_range(0, 1)) begin
          // Falling response: swap the output ends.
          dcen = dmin;
          dmin = dmax;
          dmax = dcen;
          dcen = $urandom_range(0, 1) ? 0 : dmin / 2;
        end
      end
      6: begin
        amin = $urandom_range(0, 1) ? 1023 : 0;
        acen = $urandom_range(0, 2) == 0 ? $urandom_range(0, 1023) : 512;
        amax = $urandom_range(0, 1) ? 1023 : 0;
        dmin = $urandom_range(0, 1) ? 32767 : -32768;
        dcen = $urandom_range(0, 1) ? 32767 : -32768;
        dmax = $urandom_range(0, 1) ? 32767 : -32768;
      end
      7: begin
        acen = $urandom_range(0, 1023);
        amin = $urandom_range(0, 1) ? acen : $urandom_range(0, 1023);
        amax = (amin == acen) ? $urandom_range(0, 1023) : acen;
        dmin = $urandom_range(0, 65535) - 32768;
        dcen = $urandom_range(0, 65535) - 32768;
        dmax = $urandom_range(0, 65535) - 32768;
      end
      default: begin
        amin = $urandom_range(0, 1023);
        acen = $urandom_range(0, 1023);
        amax = $urandom_range(0, 1023);
        dmin = $urandom_range(0, 65535) - 32768;
        dcen = $urandom_range(0, 65535) - 32768;
        dmax = $urandom_range(0, 65535) - 32768;
      end
    endcase
    apply_cal(amin, acen, amax, dmin, dcen, dmax);
  endtask

  initial begin
    int count, phase, random_total;
    logic [9:0] s;

    for (int i = 0; i < WINDOW_DEPTH; i++) window_taps[i] = '0;
    window_total = '0;
    // Calibration after reset.
    cal_reg[atpam_pkg::REG_AMIN] = 16'd0;
    cal_reg[atpam_pkg::REG_ACEN] = 16'd512;
    cal_reg[atpam_pkg::REG_AMAX] = 16'd1023;
    cal_reg[atpam_pkg::REG_DMIN] = -16'sd256;
    cal_reg[atpam_pkg::REG_DCEN] = 16'd0;
    cal_reg[atpam_pkg::REG_DMAX] = 16'd256;

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed part. The reset calibration comes first and is read back; the
    // first samples average against the zeros left in the window by reset.
    verify_cal();
    offer(0);   offer(1023); offer(512); offer(511); offer(513);
    offer(1);   offer(1022); offer(341); offer(682);
    offer(1023); offer(1023); offer(1023); offer(1023);
    drain();

    // Lower segment of zero width, full-scale outputs.
    apply_cal(300, 300, 800, -32768, 100, 32767);
    offer(300); offer(0); offer(301);
    drain();

    // Upper segment of zero width.
    apply_cal(100, 700, 700, -1000, -200, 500);
    offer(700); offer(701); offer(1023);
    drain();

    // Reversed stops on both sides.
    apply_cal(900, 500, 100, 1000, 0, -1000);
    offer(950); offer(50); offer(500);
    drain();

    // Steep segments that leave the 16-bit range: saturation at the top from
    // the lower segment and at the bottom from a reversed upper segment.
    apply_cal(1000, 1001, 1002, 32767, -32768, 32767);
    offer(0);
    drain();
    apply_cal(0, 10, 9, 0, -32768, 32767);
    offer(1023);
    drain();

    // Random phases, each under a fresh calibration.
    random_total = 0;
    phase = 0;
    while (random_total < RANDOM_ITEMS) begin
      random_cal();
      count = $urandom_range(60, 140);
      for (int n = 0; n < count; n++) begin
        case ($urandom_range(0, 9))
          0: s = 10'(cal_reg[atpam_pkg::REG_AMIN][9:0] + $urandom_range(0, 4) - 2);
          1: s = 10'(cal_reg[atpam_pkg::REG_ACEN][9:0] + $urandom_range(0, 4) - 2);
          2: s = 10'(cal_reg[atpam_pkg::REG_AMAX][9:0] + $urandom_range(0, 4) - 2);
          3: s = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
          default: s = 10'($urandom_range(0, 1023));
        endcase
        offer(s);
      end
      // In one phase the receiver backs off for a long time while the sender
      // keeps offering, so the block fills and holds its input off.
      if (phase == 2) hold_requests++;
      random_total += count;
      phase++;
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_readings.size() != 0)
      report_mismatch("results never delivered", pending_readings.size(), 16'h0);

    $display("summary: %0d samples in, %0d results checked, %0d calibration settings",
             samples_taken, results_seen, settings_applied);
    $display("summary: %0d random phases, one long receiver hold, %0d mismatches",
             phase, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
